// ===== rtl/spb_pkg.sv =====
package spb_pkg;

  // Default sizes for the top level parameters
  localparam int ROW_DEPTH_DEF = 4096;
  localparam int MAX_COLS_DEF  = 32;

  // Fixed field widths of the stream items
  localparam int ID_W   = 32;
  localparam int LROW_W = 12;
  localparam int CNT_W  = 6;
  localparam int STAT_W = 4;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED   = 4'd0,
    ST_DUPLICATE  = 4'd1,
    ST_MASKED     = 4'd2,
    ST_MISSING    = 4'd3,
    ST_FULL       = 4'd4,
    ST_LOADED     = 4'd5,
    ST_TABLE_FULL = 4'd6,
    ST_UNSORTED   = 4'd7,
    ST_READOUT    = 4'd8,
    ST_EMPTY      = 4'd9,
    ST_BAD_INDEX  = 4'd10
  } status_t;

  typedef struct packed {
    req_type_t         req_type;
    logic [ID_W-1:0]   row_id;
    logic [ID_W-1:0]   col_id;
    logic              row_active;
    logic              col_active;
    logic [LROW_W-1:0] read_row;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [LROW_W-1:0] local_row;
    logic [ID_W-1:0]   column;
    logic [CNT_W-1:0]  row_count;
    logic              last;
  } result_t;

  function automatic result_t make_result(status_t status, logic [LROW_W-1:0] local_row,
                                          logic [ID_W-1:0] column,
                                          logic [CNT_W-1:0] row_count, logic last);
    result_t r;
    r.status    = status;
    r.local_row = local_row;
    r.column    = column;
    r.row_count = row_count;
    r.last      = last;
    return r;
  endfunction

endpackage

// ===== rtl/spb_ram.sv =====
module spb_ram #(
  parameter int DEPTH = spb_pkg::ROW_DEPTH_DEF,
  parameter int WIDTH = spb_pkg::ID_W,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port; read data holds until the next read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== rtl/spb_ctrl.sv =====
module spb_ctrl #(
  parameter int ROW_DEPTH = spb_pkg::ROW_DEPTH_DEF,
  parameter int MAX_COLS  = spb_pkg::MAX_COLS_DEF,
  localparam int LW   = $clog2(ROW_DEPTH),
  localparam int RW   = $clog2(ROW_DEPTH + 1),
  localparam int CW   = $clog2(MAX_COLS),
  localparam int NW   = $clog2(MAX_COLS + 1),
  localparam int RMW  = NW + spb_pkg::ID_W,
  localparam int CAW  = LW + CW,
  localparam int CMPW = (RW > spb_pkg::LROW_W) ? RW : spb_pkg::LROW_W
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  spb_pkg::req_t            req,
  output logic                     res_valid,
  input  logic                     res_ready,
  output spb_pkg::result_t         res,
  output logic                     row_en,
  output logic                     row_we,
  output logic [LW-1:0]            row_addr,
  output logic [RMW-1:0]           row_wdata,
  input  logic [RMW-1:0]           row_rdata,
  output logic                     col_en,
  output logic                     col_we,
  output logic [CAW-1:0]           col_addr,
  output logic [spb_pkg::ID_W-1:0] col_wdata,
  input  logic [spb_pkg::ID_W-1:0] col_rdata
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SRCH_RD  = 7'b0000010,
    S_SRCH_CMP = 7'b0000100,
    S_SCAN     = 7'b0001000,
    S_RD_CNT   = 7'b0010000,
    S_RO_EMIT  = 7'b0100000,
    S_EMIT     = 7'b1000000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [RW-1:0]              rows_loaded_r, rows_loaded_nxt;
  logic [spb_pkg::ID_W-1:0]   last_id_r, last_id_nxt;
  logic [spb_pkg::ID_W-1:0]   row_id_r, row_id_nxt;
  logic [spb_pkg::ID_W-1:0]   col_id_r, col_id_nxt;
  logic [RW-1:0]              lo_r, lo_nxt;
  logic [RW-1:0]              hi_r, hi_nxt;
  logic [LW-1:0]              m_r, m_nxt;
  logic [LW-1:0]              r_r, r_nxt;
  logic [NW-1:0]              n_r, n_nxt;
  logic [NW-1:0]              i_r, i_nxt;
  logic                       pend_r, pend_nxt;
  spb_pkg::result_t           res_r, res_nxt;

  logic [RW-1:0]              mid;
  logic [NW-1:0]              row_cnt;
  logic [spb_pkg::ID_W-1:0]   row_key;
  logic [NW-1:0]              i_inc;
  logic                       ro_last;

  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign row_cnt = row_rdata[RMW-1:spb_pkg::ID_W];
  assign row_key = row_rdata[spb_pkg::ID_W-1:0];
  assign i_inc   = i_r + NW'(1);
  assign ro_last = (i_inc == n_r);

  always_comb begin
    state_nxt       = state_r;
    rows_loaded_nxt = rows_loaded_r;
    last_id_nxt     = last_id_r;
    row_id_nxt      = row_id_r;
    col_id_nxt      = col_id_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    m_nxt           = m_r;
    r_nxt           = r_r;
    n_nxt           = n_r;
    i_nxt           = i_r;
    pend_nxt        = pend_r;
    res_nxt         = res_r;
    row_en          = 1'b0;
    row_we          = 1'b0;
    row_addr        = '0;
    row_wdata       = '0;
    col_en          = 1'b0;
    col_we          = 1'b0;
    col_addr        = '0;
    col_wdata       = '0;
    req_ready       = (state_r == S_IDLE);
    res_valid       = 1'b0;
    res             = res_r;

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          row_id_nxt = req.row_id;
          col_id_nxt = req.col_id;
          unique case (req.req_type)
            spb_pkg::REQ_LOAD: begin
              state_nxt = S_EMIT;
              priority if (rows_loaded_r == RW'(ROW_DEPTH)) begin
                res_nxt = spb_pkg::make_result(spb_pkg::ST_TABLE_FULL, '0, '0, '0, 1'b1);
              end else if (rows_loaded_r != '0 && req.row_id <= last_id_r) begin
                res_nxt = spb_pkg::make_result(spb_pkg::ST_UNSORTED,
                            spb_pkg::LROW_W'(rows_loaded_r - RW'(1)), '0, '0, 1'b1);
              end else begin
                // Write the id with a zero count: a row's count is live once loaded
                row_en          = 1'b1;
                row_we          = 1'b1;
                row_addr        = rows_loaded_r[LW-1:0];
                row_wdata       = {NW'(0), req.row_id};
                last_id_nxt     = req.row_id;
                rows_loaded_nxt = rows_loaded_r + RW'(1);
                res_nxt = spb_pkg::make_result(spb_pkg::ST_LOADED,
                            spb_pkg::LROW_W'(rows_loaded_r), '0, '0, 1'b1);
              end
            end
            spb_pkg::REQ_INSERT: begin
              priority if (!req.row_active || !req.col_active) begin
                res_nxt   = spb_pkg::make_result(spb_pkg::ST_MASKED, '0, req.col_id, '0, 1'b1);
                state_nxt = S_EMIT;
              end else begin
                lo_nxt    = '0;
                hi_nxt    = rows_loaded_r;
                state_nxt = S_SRCH_RD;
              end
            end
            spb_pkg::REQ_READ: begin
              if (CMPW'(req.read_row) >= CMPW'(rows_loaded_r)) begin
                res_nxt   = spb_pkg::make_result(spb_pkg::ST_BAD_INDEX, req.read_row,
                                                 '0, '0, 1'b1);
                state_nxt = S_EMIT;
              end else begin
                row_en    = 1'b1;
                row_addr  = LW'(req.read_row);
                r_nxt     = LW'(req.read_row);
                state_nxt = S_RD_CNT;
              end
            end
            spb_pkg::REQ_NONE: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_SRCH_RD: begin
        if (lo_r < hi_r) begin
          row_en    = 1'b1;
          row_addr  = mid[LW-1:0];
          m_nxt     = mid[LW-1:0];
          state_nxt = S_SRCH_CMP;
        end else begin
          res_nxt   = spb_pkg::make_result(spb_pkg::ST_MISSING, '0, col_id_r, '0, 1'b1);
          state_nxt = S_EMIT;
        end
      end

      S_SRCH_CMP: begin
        priority if (row_key < row_id_r) begin
          lo_nxt    = RW'(m_r) + RW'(1);
          state_nxt = S_SRCH_RD;
        end else if (row_key > row_id_r) begin
          hi_nxt    = RW'(m_r);
          state_nxt = S_SRCH_RD;
        end else begin
          r_nxt     = m_r;
          n_nxt     = row_cnt;
          i_nxt     = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_SCAN;
        end
      end

      // One column read issued per cycle, compared in the cycle after
      S_SCAN: begin
        priority if (pend_r && col_rdata == col_id_r) begin
          res_nxt   = spb_pkg::make_result(spb_pkg::ST_DUPLICATE, spb_pkg::LROW_W'(r_r),
                                           col_id_r, spb_pkg::CNT_W'(n_r), 1'b1);
          state_nxt = S_EMIT;
        end else if (i_r < n_r) begin
          col_en   = 1'b1;
          col_addr = {r_r, i_r[CW-1:0]};
          i_nxt    = i_inc;
          pend_nxt = 1'b1;
        end else if (n_r >= NW'(MAX_COLS)) begin
          res_nxt   = spb_pkg::make_result(spb_pkg::ST_FULL, spb_pkg::LROW_W'(r_r),
                                           col_id_r, spb_pkg::CNT_W'(n_r), 1'b1);
          state_nxt = S_EMIT;
        end else begin
          col_en    = 1'b1;
          col_we    = 1'b1;
          col_addr  = {r_r, n_r[CW-1:0]};
          col_wdata = col_id_r;
          row_en    = 1'b1;
          row_we    = 1'b1;
          row_addr  = r_r;
          row_wdata = {n_r + NW'(1), row_id_r};
          res_nxt   = spb_pkg::make_result(spb_pkg::ST_INSERTED, spb_pkg::LROW_W'(r_r),
                                           col_id_r, spb_pkg::CNT_W'(n_r + NW'(1)), 1'b1);
          state_nxt = S_EMIT;
        end
      end

      S_RD_CNT: begin
        n_nxt = row_cnt;
        if (row_cnt == '0) begin
          res_nxt   = spb_pkg::make_result(spb_pkg::ST_EMPTY, spb_pkg::LROW_W'(r_r),
                                           '0, '0, 1'b1);
          state_nxt = S_EMIT;
        end else begin
          col_en    = 1'b1;
          col_addr  = {r_r, CW'(0)};
          i_nxt     = '0;
          state_nxt = S_RO_EMIT;
        end
      end

      // Column data holds in the RAM output until the next read
      S_RO_EMIT: begin
        res_valid = 1'b1;
        res       = spb_pkg::make_result(spb_pkg::ST_READOUT, spb_pkg::LROW_W'(r_r),
                                         col_rdata, spb_pkg::CNT_W'(n_r), ro_last);
        if (res_ready) begin
          if (ro_last) begin
            state_nxt = S_IDLE;
          end else begin
            col_en   = 1'b1;
            col_addr = {r_r, i_inc[CW-1:0]};
            i_nxt    = i_inc;
          end
        end
      end

      S_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      rows_loaded_r <= '0;
      pend_r        <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      rows_loaded_r <= rows_loaded_nxt;
      pend_r        <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_id_r <= last_id_nxt;
    row_id_r  <= row_id_nxt;
    col_id_r  <= col_id_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    m_r       <= m_nxt;
    r_r       <= r_nxt;
    n_r       <= n_nxt;
    i_r       <= i_nxt;
    res_r     <= res_nxt;
  end

endmodule

// ===== rtl/sparsity_pattern_builder.sv =====
// Sparsity pattern builder: keeps the set of nonzero column ids of each row.
// Input stream (in_*): one transfer per request. in_tuser carries the kind:
// load a row id (ids must rise strictly), insert a (row id, column id) pair,
// or read out one row. Output stream (out_*): one result per load or insert,
// one per stored column on readout (out_tlast marks the final one).
// Requests are handled one at a time:
//   load or masked insert: the result passes S_EMIT into the output register;
//   insert: a binary search over the loaded row table, each step a read
//   (S_SRCH_RD) and a compare (S_SRCH_CMP), then a scan of the stored
//   columns of the row, then S_EMIT and the output register;
//   readout: the row count is read, then one column per cycle unless stalled.
// The row table (id and column count per row) and the column store are
// single port RAMs with a registered read; the search and the column scan
// are set by that port. A row's count is zeroed when the row is loaded,
// so no clearing pass is needed after reset.
// Reset (rst_n low, synchronous) empties the row table and drops any result.
// When out_tready is low the result holds in the output register, and the
// sequencer stalls on its next result.
module sparsity_pattern_builder #(
  parameter int ROW_DEPTH = spb_pkg::ROW_DEPTH_DEF,
  parameter int MAX_COLS  = spb_pkg::MAX_COLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // row_id[31:0], col_id[63:32], row_active[64], col_active[65], read_row[77:66]
  input  logic [79:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // local_row[11:0], column[43:12], row_count[49:44]
  output logic [55:0] out_tdata,
  // status[3:0]
  output logic [3:0]  out_tuser,
  output logic        out_tlast
);

  localparam int LW  = $clog2(ROW_DEPTH);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int NW  = $clog2(MAX_COLS + 1);
  localparam int RMW = NW + spb_pkg::ID_W;
  localparam int CAW = LW + CW;

  spb_pkg::req_t            req;
  spb_pkg::result_t         res;
  logic                     res_valid;
  logic                     res_ready;

  logic                     row_en, row_we;
  logic [LW-1:0]            row_addr;
  logic [RMW-1:0]           row_wdata, row_rdata;
  logic                     col_en, col_we;
  logic [CAW-1:0]           col_addr;
  logic [spb_pkg::ID_W-1:0] col_wdata, col_rdata;

  logic                     out_valid_r;
  spb_pkg::result_t         out_res_r;

  // Unpack the request transfer
  assign req.req_type   = spb_pkg::req_type_t'(in_tuser);
  assign req.row_id     = in_tdata[31:0];
  assign req.col_id     = in_tdata[63:32];
  assign req.row_active = in_tdata[64];
  assign req.col_active = in_tdata[65];
  assign req.read_row   = in_tdata[77:66];

  spb_ctrl #(
    .ROW_DEPTH(ROW_DEPTH),
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(in_tvalid),
    .req_ready(in_tready),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .row_en   (row_en),
    .row_we   (row_we),
    .row_addr (row_addr),
    .row_wdata(row_wdata),
    .row_rdata(row_rdata),
    .col_en   (col_en),
    .col_we   (col_we),
    .col_addr (col_addr),
    .col_wdata(col_wdata),
    .col_rdata(col_rdata)
  );

  // Row table: {column count, global row id} per local row
  spb_ram #(
    .DEPTH(ROW_DEPTH),
    .WIDTH(RMW)
  ) u_row_ram (
    .clk  (clk),
    .en   (row_en),
    .we   (row_we),
    .addr (row_addr),
    .wdata(row_wdata),
    .rdata(row_rdata)
  );

  // Column store: MAX_COLS slots per row, rounded up to a power of two
  spb_ram #(
    .DEPTH(ROW_DEPTH * (1 << CW)),
    .WIDTH(spb_pkg::ID_W)
  ) u_col_ram (
    .clk  (clk),
    .en   (col_en),
    .we   (col_we),
    .addr (col_addr),
    .wdata(col_wdata),
    .rdata(col_rdata)
  );

  // Output register: take a new result when empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_res_r.row_count, out_res_r.column, out_res_r.local_row};
  assign out_tuser  = out_res_r.status;
  assign out_tlast  = out_res_r.last;

endmodule

// ===== sim/tb_sparsity_pattern_builder.sv =====
`timescale 1ns / 1ps

module tb_sparsity_pattern_builder;

  localparam int ROWS         = spb_pkg::ROW_DEPTH_DEF;
  localparam int COLS         = spb_pkg::MAX_COLS_DEF;
  localparam int RANDOM_ITEMS = 40;
  localparam int BURST_AT     = 30;    // random item index where the row fill burst starts
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off to back up the block
  localparam int STALL_LIMIT  = 4000;  // cycles with no transfer on either side
  localparam int DRAIN_CYCLES = 200;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;

  sparsity_pattern_builder #(
    .ROW_DEPTH(ROWS),
    .MAX_COLS (COLS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // Mirror of the row table, per-row counts and column store
  logic [spb_pkg::ID_W-1:0] row_ids [ROWS];
  int unsigned              n_rows;
  int unsigned              col_cnt [ROWS];
  logic [spb_pkg::ID_W-1:0] col_mem [ROWS*COLS];

  spb_pkg::result_t step_results[$];  // results of the request just accepted
  spb_pkg::result_t due_results[$];   // results still owed by the block, oldest first

  int errors;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_asked;
  int hold_seen;
  int hold_left;
  int stall_cycles;

  // One row of the directed request table; typed rows carry their result
  typedef struct {
    spb_pkg::req_t    req;
    bit               typed;
    spb_pkg::result_t res;
  } opening_req_t;

  opening_req_t opening_reqs[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic spb_pkg::result_t pattern_result(spb_pkg::status_t st,
                                                      logic [spb_pkg::LROW_W-1:0] lrow,
                                                      logic [spb_pkg::ID_W-1:0] col,
                                                      logic [spb_pkg::CNT_W-1:0] cnt,
                                                      logic last);
    spb_pkg::result_t r;
    r.status    = st;
    r.local_row = lrow;
    r.column    = col;
    r.row_count = cnt;
    r.last      = last;
    return r;
  endfunction

  // Append one result to those of the current request.
  function automatic void add_step(spb_pkg::result_t r);
    step_results = {step_results, r};
  endfunction

  // Advance the mirrored tables by one request and leave its results in step_results.
  function automatic void predict_pattern(spb_pkg::req_t rq);
    int lo;
    int hi;
    int mid;
    int found;
    int n;
    bit dup;
    step_results.delete();
    case (rq.req_type)
      spb_pkg::REQ_LOAD: begin
        if (n_rows >= ROWS) begin
          add_step(pattern_result(spb_pkg::ST_TABLE_FULL, '0, '0, '0, 1'b1));
        end else if (n_rows > 0 && rq.row_id <= row_ids[n_rows-1]) begin
          add_step(pattern_result(spb_pkg::ST_UNSORTED, spb_pkg::LROW_W'(n_rows - 1),
                                  '0, '0, 1'b1));
        end else begin
          row_ids[n_rows] = rq.row_id;
          add_step(pattern_result(spb_pkg::ST_LOADED, spb_pkg::LROW_W'(n_rows), '0,
                                  spb_pkg::CNT_W'(col_cnt[n_rows]), 1'b1));
          n_rows++;
        end
      end
      spb_pkg::REQ_INSERT: begin
        if (!rq.row_active || !rq.col_active) begin
          add_step(pattern_result(spb_pkg::ST_MASKED, '0, rq.col_id, '0, 1'b1));
        end else begin
          // binary search over the sorted row ids
          found = -1;
          lo    = 0;
          hi    = n_rows;
          while (lo < hi && found < 0) begin
            mid = lo + (hi - lo) / 2;
            if (row_ids[mid] < rq.row_id) lo = mid + 1;
            else if (row_ids[mid] > rq.row_id) hi = mid;
            else found = mid;
          end
          if (found < 0) begin
            add_step(pattern_result(spb_pkg::ST_MISSING, '0, rq.col_id, '0, 1'b1));
          end else begin
            n   = col_cnt[found];
            dup = 1'b0;
            for (int i = 0; i < n; i++) begin
              if (col_mem[found*COLS + i] == rq.col_id) dup = 1'b1;
            end
            if (dup) begin
              add_step(pattern_result(spb_pkg::ST_DUPLICATE, spb_pkg::LROW_W'(found),
                                      rq.col_id, spb_pkg::CNT_W'(n), 1'b1));
            end else if (n >= COLS) begin
              add_step(pattern_result(spb_pkg::ST_FULL, spb_pkg::LROW_W'(found),
                                      rq.col_id, spb_pkg::CNT_W'(n), 1'b1));
            end else begin
              col_mem[found*COLS + n] = rq.col_id;
              col_cnt[found]          = n + 1;
              add_step(pattern_result(spb_pkg::ST_INSERTED, spb_pkg::LROW_W'(found),
                                      rq.col_id, spb_pkg::CNT_W'(n + 1), 1'b1));
            end
          end
        end
      end
      spb_pkg::REQ_READ: begin
        if (int'(rq.read_row) >= n_rows) begin
          add_step(pattern_result(spb_pkg::ST_BAD_INDEX, rq.read_row, '0, '0, 1'b1));
        end else if (col_cnt[rq.read_row] == 0) begin
          add_step(pattern_result(spb_pkg::ST_EMPTY, rq.read_row, '0, '0, 1'b1));
        end else begin
          n = col_cnt[rq.read_row];
          for (int i = 0; i < n; i++) begin
            add_step(pattern_result(spb_pkg::ST_READOUT, rq.read_row,
                                    col_mem[int'(rq.read_row)*COLS + i],
                                    spb_pkg::CNT_W'(n), i == n - 1));
          end
        end
      end
      default: ;  // unused request type: dropped without a result
    endcase
  endfunction

  // Random content in every field; callers override what matters.
  function automatic spb_pkg::req_t rand_req(spb_pkg::req_type_t t);
    spb_pkg::req_t rq;
    rq.req_type   = t;
    rq.row_id     = $urandom;
    rq.col_id     = $urandom;
    rq.row_active = 1'($urandom_range(1));
    rq.col_active = 1'($urandom_range(1));
    rq.read_row   = spb_pkg::LROW_W'($urandom_range(ROWS - 1));
    return rq;
  endfunction

  function automatic void add_opening(spb_pkg::req_type_t t, logic [spb_pkg::ID_W-1:0] rid,
                                      logic [spb_pkg::ID_W-1:0] cid, logic ract, logic cact,
                                      logic [spb_pkg::LROW_W-1:0] rrow, bit typed = 1'b0,
                                      spb_pkg::status_t st = spb_pkg::ST_INSERTED,
                                      logic [spb_pkg::LROW_W-1:0] lrow = '0,
                                      logic [spb_pkg::ID_W-1:0] col = '0,
                                      logic [spb_pkg::CNT_W-1:0] cnt = '0);
    opening_req_t o;
    o.req.req_type   = t;
    o.req.row_id     = rid;
    o.req.col_id     = cid;
    o.req.row_active = ract;
    o.req.col_active = cact;
    o.req.read_row   = rrow;
    o.typed          = typed;
    o.res            = pattern_result(st, lrow, col, cnt, 1'b1);
    opening_reqs     = {opening_reqs, o};
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [spb_pkg::ID_W-1:0] got,
                             logic [spb_pkg::ID_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  // Offer one request until it transfers, then book its expected results.
  // tvalid stays high between back-to-back requests; drop it only for an idle gap.
  task automatic send_req(spb_pkg::req_t rq, bit typed = 1'b0, spb_pkg::result_t want = '0);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, rq.read_row, rq.col_active, rq.row_active, rq.col_id, rq.row_id};
    in_tuser  <= rq.req_type;
    do @(posedge clk); while (!in_tready);
    predict_pattern(rq);
    if (typed) due_results = {due_results, want};
    else foreach (step_results[i]) due_results = {due_results, step_results[i]};
  endtask

  // Fill one row to its limit, hit it with a duplicate and an overflow, then
  // read it out while the receiver holds off so the block backs up.
  task automatic fill_one_row();
    spb_pkg::req_t rq;
    int            ri;
    ri = $urandom_range(n_rows - 1);
    while (col_cnt[ri] < COLS) begin
      rq            = rand_req(spb_pkg::REQ_INSERT);
      rq.row_id     = row_ids[ri];
      rq.row_active = 1'b1;
      rq.col_active = 1'b1;
      send_req(rq);
    end
    rq            = rand_req(spb_pkg::REQ_INSERT);
    rq.row_id     = row_ids[ri];
    rq.row_active = 1'b1;
    rq.col_active = 1'b1;
    rq.col_id     = col_mem[ri*COLS + $urandom_range(COLS - 1)];
    send_req(rq);
    rq.col_id = $urandom;
    send_req(rq);
    hold_asked++;
    rq          = rand_req(spb_pkg::REQ_READ);
    rq.read_row = spb_pkg::LROW_W'(ri);
    send_req(rq);
  endtask

  // Result side: check each transfer against the oldest expectation, then
  // decide tready for the next edge.
  always @(posedge clk) begin
    spb_pkg::result_t got;
    spb_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status    = spb_pkg::status_t'(out_tuser);
      got.local_row = out_tdata[11:0];
      got.column    = out_tdata[43:12];
      got.row_count = out_tdata[49:44];
      got.last      = out_tlast;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d row %0d column %0h",
                                  got.status, got.local_row, got.column));
      end else begin
        want = due_results.pop_front();
        check_field("status", 32'(got.status), 32'(want.status));
        check_field("local_row", 32'(got.local_row), 32'(want.local_row));
        check_field("column", got.column, want.column);
        check_field("row_count", 32'(got.row_count), 32'(want.row_count));
        check_field("last", 32'(got.last), 32'(want.last));
      end
    end
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run when neither side has moved for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TIMEOUT: no transfer for %0d cycles, %0d results outstanding",
               stall_cycles, due_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    spb_pkg::req_t            rq;
    int                       n;
    int                       ri;
    int                       pick;
    bit                       burst_done;
    logic [spb_pkg::ID_W-1:0] last_id;

    rst_n         <= 1'b0;
    in_tvalid     <= 1'b0;
    in_tdata      <= '0;
    in_tuser      <= spb_pkg::REQ_NONE;
    errors        = 0;
    n_rows        = 0;
    hold_asked    = 0;
    hold_seen     = 0;
    hold_left     = 0;
    stall_cycles  = 0;
    burst_done    = 1'b0;
    send_idle_pct = 29;
    recv_idle_pct = 71;
    foreach (col_cnt[i]) col_cnt[i] = 0;

    // Directed part: reads and inserts on an empty table, ordering errors,
    // masking, search misses between and above the loaded ids, field extremes.
    add_opening(spb_pkg::REQ_READ, '0, '0, 1'b1, 1'b1, '0,
                1'b1, spb_pkg::ST_BAD_INDEX, '0, '0, '0);
    add_opening(spb_pkg::REQ_INSERT, 32'd5, 32'd7, 1'b1, 1'b1, '0,
                1'b1, spb_pkg::ST_MISSING, '0, 32'd7, '0);
    add_opening(spb_pkg::REQ_LOAD, '0, '0, 1'b0, 1'b0, '0,
                1'b1, spb_pkg::ST_LOADED, '0, '0, '0);
    add_opening(spb_pkg::REQ_LOAD, '0, '0, 1'b1, 1'b1, '0,
                1'b1, spb_pkg::ST_UNSORTED, '0, '0, '0);
    add_opening(spb_pkg::REQ_LOAD, 32'h10, '1, 1'b1, 1'b1, '1);
    add_opening(spb_pkg::REQ_LOAD, 32'h0F, '0, 1'b0, 1'b0, '0,
                1'b1, spb_pkg::ST_UNSORTED, 12'd1, '0, '0);
    add_opening(spb_pkg::REQ_LOAD, 32'h8000_0000, '0, 1'b0, 1'b0, '0);
    add_opening(spb_pkg::REQ_READ, '0, '0, 1'b0, 1'b0, 12'd1,
                1'b1, spb_pkg::ST_EMPTY, 12'd1, '0, '0);
    add_opening(spb_pkg::REQ_READ, '1, '1, 1'b1, 1'b1, '1,
                1'b1, spb_pkg::ST_BAD_INDEX, '1, '0, '0);
    add_opening(spb_pkg::REQ_INSERT, '0, '0, 1'b0, 1'b1, '0,
                1'b1, spb_pkg::ST_MASKED, '0, '0, '0);
    add_opening(spb_pkg::REQ_INSERT, '0, '1, 1'b1, 1'b0, '0,
                1'b1, spb_pkg::ST_MASKED, '0, '1, '0);
    add_opening(spb_pkg::REQ_INSERT, 32'h10, 32'h55, 1'b0, 1'b0, '0,
                1'b1, spb_pkg::ST_MASKED, '0, 32'h55, '0);
    add_opening(spb_pkg::REQ_INSERT, '0, '0, 1'b1, 1'b1, '0);
    add_opening(spb_pkg::REQ_INSERT, '0, '1, 1'b1, 1'b1, '0);
    add_opening(spb_pkg::REQ_INSERT, '0, '0, 1'b1, 1'b1, '0);
    add_opening(spb_pkg::REQ_INSERT, 32'h8000_0000, 32'h1234_5678, 1'b1, 1'b1, '0);
    add_opening(spb_pkg::REQ_INSERT, 32'h7FFF_FFFF, 32'd1, 1'b1, 1'b1, '0,
                1'b1, spb_pkg::ST_MISSING, '0, 32'd1, '0);
    add_opening(spb_pkg::REQ_INSERT, '1, 32'd2, 1'b1, 1'b1, '0,
                1'b1, spb_pkg::ST_MISSING, '0, 32'd2, '0);
    add_opening(spb_pkg::REQ_INSERT, 32'h10, 32'hA5A5_A5A5, 1'b1, 1'b1, '1);
    add_opening(spb_pkg::REQ_READ, '0, '0, 1'b0, 1'b0, 12'd0);
    add_opening(spb_pkg::REQ_READ, '1, '0, 1'b1, 1'b1, 12'd2);
    add_opening(spb_pkg::REQ_NONE, '1, '1, 1'b1, 1'b1, '1);
    add_opening(spb_pkg::REQ_READ, '0, '0, 1'b0, 1'b0, 12'd3,
                1'b1, spb_pkg::ST_BAD_INDEX, 12'd3, '0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_reqs[k]) send_req(opening_reqs[k].req, opening_reqs[k].typed,
                                       opening_reqs[k].res);

    // Random part: mostly inserts and readouts on loaded rows, some loads
    // (a quarter of them out of order), misses, masked pairs and dropped types.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n >= 2*RANDOM_ITEMS/3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (n >= RANDOM_ITEMS/3) begin
        send_idle_pct = 71;
        recv_idle_pct = 29;
      end
      if (n >= BURST_AT && !burst_done) begin
        burst_done = 1'b1;
        fill_one_row();
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
        rq      = rand_req(spb_pkg::REQ_LOAD);
        last_id = row_ids[n_rows-1];
        if ($urandom_range(3) == 0) rq.row_id = $urandom_range(last_id);
        else rq.row_id = last_id + $urandom_range(1 << 20, 1);
      end else if (pick < 55) begin
        rq        = rand_req(spb_pkg::REQ_INSERT);
        ri        = $urandom_range(n_rows - 1);
        rq.row_id = row_ids[ri];
        if ($urandom_range(1)) rq.col_id = $urandom_range(15);
        if ($urandom_range(9) != 0) begin
          rq.row_active = 1'b1;
          rq.col_active = 1'b1;
        end
      end else if (pick < 65) begin
        rq = rand_req(spb_pkg::REQ_INSERT);
        if ($urandom_range(3) != 0) begin
          rq.row_active = 1'b1;
          rq.col_active = 1'b1;
        end
      end else if (pick < 90) begin
        rq = rand_req(spb_pkg::REQ_READ);
        if ($urandom_range(4) != 0) begin
          rq.read_row = spb_pkg::LROW_W'($urandom_range(n_rows - 1));
        end
      end else begin
        rq = rand_req(spb_pkg::REQ_NONE);
      end
      send_req(rq);
      if (rq.req_type != spb_pkg::REQ_NONE) n++;
    end

    // Search the loaded table at both ends and in between.
    for (int k = 0; k < 6; k++) begin
      ri = (k == 0) ? 0 : (k == 1) ? int'(n_rows) - 1 : $urandom_range(n_rows - 1);
      rq = rand_req((k % 3 == 2) ? spb_pkg::REQ_READ : spb_pkg::REQ_INSERT);
      rq.row_id     = row_ids[ri];
      rq.row_active = 1'b1;
      rq.col_active = 1'b1;
      rq.read_row   = spb_pkg::LROW_W'(ri);
      send_req(rq);
    end

    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    // give a stray late result the chance to show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
